[rtl/rmh_pkg.sv]
// Shared types and constants for the running median block.
// Used by rmh_ctrl, rmh_dp and running_median_two_heaps.
`default_nettype none
package rmh_pkg;

    localparam int DEF_CAPACITY     = 1024;
    localparam int DEF_SAMPLE_WIDTH = 32;
    localparam int COUNT_OUT_W      = 11;

    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PU_CHK,
        ST_PU_CMP,
        ST_RT_CHK,
        ST_RT_L,
        ST_RT_R,
        ST_RT_CMP,
        ST_OUT
    } rmh_state_t;

    typedef struct packed {
        logic load;
        logic push_init;
        logic rt_init;
        logic from_carry;
        logic save_carry;
        logic sel;
        logic rd_parent;
        logic rd_left;
        logic rd_right;
        logic cap_left;
        logic cap_right;
        logic wr_val;
        logic move_up;
        logic move_down;
        logic out_load;
    } rmh_cmd_t;

    typedef struct packed {
        logic is_root;
        logic above_par;
        logic l_in;
        logic r_in;
        logic best_above;
        logic full;
        logic go_lower;
        logic low_gt_up;
        logic up_ge_low;
        logic to_lower2;
        logic out_free;
    } rmh_stat_t;

endpackage
`default_nettype wire

[rtl/rmh_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module rmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/rmh_ctrl.sv]
// Sequencer for heap push and replace-top operations.
// Depends on rmh_pkg; drives rmh_dp through command/status structs.
`default_nettype none
module rmh_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire rmh_pkg::rmh_stat_t stat,
    output rmh_pkg::rmh_cmd_t       cmd
);
    import rmh_pkg::*;

    rmh_state_t state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        fin        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.full) begin
                    state_next = ST_OUT;
                end else if (stat.go_lower) begin
                    cmd.sel = HEAP_LOWER;
                    if (stat.low_gt_up) begin
                        cmd.save_carry = 1'b1;
                        cmd.rt_init    = 1'b1;
                        pend_next      = 1'b1;
                        state_next     = ST_RT_CHK;
                    end else begin
                        cmd.push_init = 1'b1;
                        state_next    = ST_PU_CHK;
                    end
                end else if (stat.up_ge_low) begin
                    if (stat.to_lower2) begin
                        cmd.sel       = HEAP_LOWER;
                        cmd.push_init = 1'b1;
                        state_next    = ST_PU_CHK;
                    end else begin
                        cmd.sel        = HEAP_UPPER;
                        cmd.save_carry = 1'b1;
                        cmd.rt_init    = 1'b1;
                        pend_next      = 1'b1;
                        state_next     = ST_RT_CHK;
                    end
                end else begin
                    cmd.sel       = HEAP_UPPER;
                    cmd.push_init = 1'b1;
                    state_next    = ST_PU_CHK;
                end
            end
            ST_PU_CHK: begin
                if (stat.is_root) begin
                    cmd.wr_val = 1'b1;
                    fin        = 1'b1;
                end else begin
                    cmd.rd_parent = 1'b1;
                    state_next    = ST_PU_CMP;
                end
            end
            ST_PU_CMP: begin
                if (stat.above_par) begin
                    cmd.move_up = 1'b1;
                    state_next  = ST_PU_CHK;
                end else begin
                    cmd.wr_val = 1'b1;
                    fin        = 1'b1;
                end
            end
            ST_RT_CHK: begin
                if (!stat.l_in) begin
                    cmd.wr_val = 1'b1;
                    fin        = 1'b1;
                end else begin
                    cmd.rd_left = 1'b1;
                    state_next  = ST_RT_L;
                end
            end
            ST_RT_L: begin
                cmd.cap_left = 1'b1;
                if (stat.r_in) begin
                    cmd.rd_right = 1'b1;
                    state_next   = ST_RT_R;
                end else begin
                    state_next = ST_RT_CMP;
                end
            end
            ST_RT_R: begin
                cmd.cap_right = 1'b1;
                state_next    = ST_RT_CMP;
            end
            ST_RT_CMP: begin
                if (stat.best_above) begin
                    cmd.move_down = 1'b1;
                    state_next    = ST_RT_CHK;
                end else begin
                    cmd.wr_val = 1'b1;
                    fin        = 1'b1;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // second phase of a rebalance: push the displaced top
        if (fin) begin
            if (pend_reg) begin
                cmd.from_carry = 1'b1;
                pend_next      = 1'b0;
                state_next     = ST_PU_CHK;
            end else begin
                state_next = ST_OUT;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/rmh_dp.sv]
// Datapath: both heap RAMs, tops, counts, sift registers and result register.
// Depends on rmh_pkg and rmh_ram; commanded by rmh_ctrl.
`default_nettype none
module rmh_dp #(
    parameter int CAPACITY     = rmh_pkg::DEF_CAPACITY,
    parameter int SAMPLE_WIDTH = rmh_pkg::DEF_SAMPLE_WIDTH,
    parameter int SIN_W        = ((SAMPLE_WIDTH + 7) / 8) * 8,
    parameter int SOUT_W       = ((SAMPLE_WIDTH + 1 + rmh_pkg::COUNT_OUT_W + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [SIN_W-1:0]  s_tdata,
    input  wire rmh_pkg::rmh_cmd_t cmd,
    output rmh_pkg::rmh_stat_t     stat,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [SOUT_W-1:0]      m_tdata,
    output logic                   m_tuser
);
    import rmh_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int LD = (CAPACITY + 1) / 2;
    localparam int CW = $clog2(LD + 1);
    localparam int AW = (LD > 1) ? $clog2(LD) : 1;
    localparam int MW = SW + 1;

    logic signed [SW-1:0] sample_reg;
    logic signed [SW-1:0] val_reg, carry_reg, best_reg;
    logic signed [SW-1:0] ltop_reg, utop_reg;
    logic [CW-1:0]        lcnt_reg, ucnt_reg;
    logic [CW-1:0]        idx_reg, bidx_reg;
    logic                 sel_reg, push_reg, drop_reg;
    logic                 ovalid_reg;
    logic [MW-1:0]        omed_reg;
    logic [COUNT_OUT_W-1:0] ocnt_reg;
    logic                 odrop_reg;

    logic signed [SW-1:0] rdata, lrdata, urdata, wdata;
    logic [CW:0]          lchild, rchild, total, ncnt;
    logic [CW-1:0]        parent, selcnt;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [MW-1:0]        med;

    function automatic logic above(input logic signed [SW-1:0] a,
                                   input logic signed [SW-1:0] b,
                                   input logic is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    assign selcnt = (sel_reg == HEAP_LOWER) ? lcnt_reg : ucnt_reg;
    assign lchild = {idx_reg, 1'b1};
    assign rchild = lchild + (CW+1)'(1);
    assign parent = (idx_reg - CW'(1)) >> 1;
    assign ncnt   = {1'b0, selcnt};
    assign total  = {1'b0, lcnt_reg} + {1'b0, ucnt_reg};
    assign rdata  = (sel_reg == HEAP_LOWER) ? lrdata : urdata;

    always_comb begin
        raddr = '0;
        if (cmd.rd_parent) begin
            raddr = parent[AW-1:0];
        end else if (cmd.rd_left) begin
            raddr = lchild[AW-1:0];
        end else if (cmd.rd_right) begin
            raddr = rchild[AW-1:0];
        end
        wdata = val_reg;
        if (cmd.move_up) begin
            wdata = rdata;
        end else if (cmd.move_down) begin
            wdata = best_reg;
        end
    end

    assign we = cmd.wr_val || cmd.move_up || cmd.move_down;

    rmh_ram #(.WIDTH(SW), .DEPTH(LD)) u_lower (
        .aclk (aclk),
        .we   (we && sel_reg == HEAP_LOWER),
        .waddr(idx_reg[AW-1:0]),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(lrdata)
    );

    rmh_ram #(.WIDTH(SW), .DEPTH(LD)) u_upper (
        .aclk (aclk),
        .we   (we && sel_reg == HEAP_UPPER),
        .waddr(idx_reg[AW-1:0]),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(urdata)
    );

    always_comb begin
        med = '0;
        if (lcnt_reg != '0) begin
            if (lcnt_reg == ucnt_reg) begin
                med = {ltop_reg[SW-1], ltop_reg} + {utop_reg[SW-1], utop_reg};
            end else begin
                med = {ltop_reg, 1'b0};
            end
        end
    end

    always_comb begin
        stat            = '0;
        stat.is_root    = (idx_reg == '0);
        stat.above_par  = above(val_reg, rdata, sel_reg == HEAP_LOWER);
        stat.l_in       = lchild < ncnt;
        stat.r_in       = rchild < ncnt;
        stat.best_above = above(best_reg, val_reg, sel_reg == HEAP_LOWER);
        stat.full       = drop_reg;
        stat.go_lower   = (lcnt_reg == '0) || (ltop_reg >= sample_reg);
        stat.low_gt_up  = lcnt_reg > ucnt_reg;
        stat.up_ge_low  = ucnt_reg >= lcnt_reg;
        stat.to_lower2  = (ucnt_reg == '0) || (sample_reg <= utop_reg);
        stat.out_free   = !ovalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_tdata[SW-1:0];
            drop_reg   <= total >= (CW+1)'(CAPACITY);
        end
        if (cmd.save_carry) begin
            carry_reg <= (cmd.sel == HEAP_LOWER) ? ltop_reg : utop_reg;
        end
        if (cmd.push_init || cmd.rt_init) begin
            sel_reg  <= cmd.sel;
            push_reg <= cmd.push_init;
            val_reg  <= sample_reg;
            idx_reg  <= cmd.push_init
                        ? ((cmd.sel == HEAP_LOWER) ? lcnt_reg : ucnt_reg) : '0;
        end else if (cmd.from_carry) begin
            // carried top goes to the other heap, loaded with the finishing write
            sel_reg  <= ~sel_reg;
            push_reg <= 1'b1;
            val_reg  <= carry_reg;
            idx_reg  <= (sel_reg == HEAP_LOWER) ? ucnt_reg : lcnt_reg;
        end
        if (cmd.move_up) begin
            idx_reg <= parent;
        end
        if (cmd.move_down) begin
            idx_reg <= bidx_reg;
        end
        if (cmd.cap_left) begin
            best_reg <= rdata;
            bidx_reg <= lchild[CW-1:0];
        end
        if (cmd.cap_right && above(rdata, best_reg, sel_reg == HEAP_LOWER)) begin
            best_reg <= rdata;
            bidx_reg <= rchild[CW-1:0];
        end
        if (we && idx_reg == '0) begin
            if (sel_reg == HEAP_LOWER) begin
                ltop_reg <= wdata;
            end else begin
                utop_reg <= wdata;
            end
        end
        if (cmd.out_load) begin
            omed_reg  <= med;
            ocnt_reg  <= COUNT_OUT_W'(total);
            odrop_reg <= drop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcnt_reg   <= '0;
            ucnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cmd.wr_val && push_reg) begin
                if (sel_reg == HEAP_LOWER) begin
                    lcnt_reg <= lcnt_reg + CW'(1);
                end else begin
                    ucnt_reg <= ucnt_reg + CW'(1);
                end
            end
            if (cmd.out_load) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = SOUT_W'({ocnt_reg, omed_reg});
    assign m_tuser  = odrop_reg;
endmodule
`default_nettype wire

[rtl/running_median_two_heaps.sv]
// Running median: a full store skips the heaps and is the shortest path from input
// transfer to m_tvalid; a replace-top sift plus a push over up to nine heap levels
// takes the longest. One sample in flight; the next can be taken in the cycle after
// the result is registered.
// Reset (aresetn, synchronous) empties both heaps; heap RAMs are not cleared.
// Depends on rmh_pkg, rmh_ctrl, rmh_dp, rmh_ram.
`default_nettype none
module running_median_two_heaps #(
    parameter int CAPACITY     = rmh_pkg::DEF_CAPACITY,
    parameter int SAMPLE_WIDTH = rmh_pkg::DEF_SAMPLE_WIDTH,
    parameter int SIN_W        = ((SAMPLE_WIDTH + 7) / 8) * 8,
    parameter int SOUT_W       = ((SAMPLE_WIDTH + 1 + rmh_pkg::COUNT_OUT_W + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [SIN_W-1:0]  s_tdata,   // sample
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [SOUT_W-1:0]      m_tdata,   // median_doubled, stored_count
    output logic                   m_tuser    // dropped_full
);
    import rmh_pkg::*;

    rmh_cmd_t  cmd;
    rmh_stat_t stat;

    rmh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rmh_dp #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .SIN_W       (SIN_W),
        .SOUT_W      (SOUT_W)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for running_median_two_heaps: directed and random
// samples over the stream bus, checked against a two-heap median scoreboard.
// Depends on rmh_pkg and the running_median_two_heaps RTL.
`default_nettype none

class median_scoreboard;
    localparam int CAP = rmh_pkg::DEF_CAPACITY;
    longint heap[2][CAP/2+1];   // 0: lower max-heap, 1: upper min-heap
    int     cnt[2];
    logic [32:0] exp_med[$];
    logic [10:0] exp_cnt[$];
    logic        exp_drop[$];
    int errors;
    int checked;
    int drops;

    function new();
        cnt[0] = 0;
        cnt[1] = 0;
        errors = 0;
        checked = 0;
        drops = 0;
    endfunction

    function bit above(longint a, longint b, int k);
        return (k == 0) ? (a > b) : (a < b);
    endfunction

    function void push(int k, longint v);
        int i;
        int p;
        i = cnt[k];
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!above(v, heap[k][p], k)) break;
            heap[k][i] = heap[k][p];
            i = p;
        end
        heap[k][i] = v;
        cnt[k]++;
    endfunction

    function void replace_top(int k, longint v);
        int i;
        int l;
        int b;
        i = 0;
        forever begin
            l = 2 * i + 1;
            if (l >= cnt[k]) break;
            b = l;
            if (l + 1 < cnt[k] && above(heap[k][l+1], heap[k][l], k)) b = l + 1;
            if (!above(heap[k][b], v, k)) break;
            heap[k][i] = heap[k][b];
            i = b;
        end
        heap[k][i] = v;
    endfunction

    function void note_sample(logic signed [31:0] raw);
        longint s;
        longint t;
        longint m;
        bit drop;
        s = raw;
        drop = 0;
        m = 0;
        if (cnt[0] + cnt[1] >= CAP) begin
            drop = 1;
            drops++;
        end else if (cnt[0] == 0 || heap[0][0] >= s) begin
            if (cnt[0] > cnt[1]) begin
                t = heap[0][0];
                replace_top(0, s);
                push(1, t);
            end else begin
                push(0, s);
            end
        end else if (cnt[1] >= cnt[0]) begin
            if (cnt[1] == 0 || s <= heap[1][0]) begin
                push(0, s);
            end else begin
                t = heap[1][0];
                replace_top(1, s);
                push(0, t);
            end
        end else begin
            push(1, s);
        end
        if (cnt[0] > 0)
            m = (cnt[0] == cnt[1]) ? heap[0][0] + heap[1][0] : heap[0][0] * 2;
        exp_med.push_back(m[32:0]);
        exp_cnt.push_back(11'(cnt[0] + cnt[1]));
        exp_drop.push_back(drop);
    endfunction

    function void check_result(logic [32:0] med, logic [10:0] count, logic drop);
        logic [32:0] em;
        logic [10:0] ec;
        logic        ed;
        if (exp_med.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
            return;
        end
        em = exp_med.pop_front();
        ec = exp_cnt.pop_front();
        ed = exp_drop.pop_front();
        checked++;
        if (med !== em) begin
            $error("median_doubled: expected %h, got %h", em, med);
            errors++;
        end
        if (count !== ec) begin
            $error("stored_count: expected %0d, got %0d", ec, count);
            errors++;
        end
        if (drop !== ed) begin
            $error("dropped_full: expected %b, got %b", ed, drop);
            errors++;
        end
    endfunction

    function int pending();
        return exp_med.size();
    endfunction
endclass

module testbench;
    localparam int N_RANDOM = 1630;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;       // sample
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;       // median_doubled, stored_count, zero pad
    logic        m_tuser;       // dropped_full

    median_scoreboard sb;
    int accepted;
    bit quiet;

    running_median_two_heaps DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_sample(s_tdata);
            accepted++;
        end
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[32:0], m_tdata[43:33], m_tuser);
    end

    // receiver: random stalls, one long hold-off
    initial begin
        bit held;
        int k;
        held = 0;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (!held && accepted >= 400) begin
                held = 1;
                m_tready = 0;
                for (k = 0; k < 300; k++) @(negedge aclk);
            end
            m_tready = quiet ? 1'b1 : ($urandom_range(99) >= 29);
        end
    end

    task automatic send_sample(logic [31:0] v);
        bit acc;
        while (!quiet && $urandom_range(99) < 29) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = v;
        do begin
            @(posedge aclk);
            acc = s_tready;
            @(negedge aclk);
        end while (!acc);
        s_tvalid = 0;
    endtask

    function automatic logic [31:0] rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 32'($signed($urandom_range(16)) - 8);
        if (r < 70) return $urandom();
        if (r < 85) return 32'h7fff_ffff - $urandom_range(3);
        return 32'h8000_0000 + $urandom_range(3);
    endfunction

    initial begin
        logic [31:0] directed[$];
        int i;
        sb = new();
        accepted = 0;
        quiet = 0;
        s_tvalid = 0;
        s_tdata = 0;
        aresetn = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        directed = '{32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff,
                     32'd1, 32'd1, 32'd1, 32'd5, 32'd4, 32'd3, 32'd2, 32'd10,
                     32'd20, 32'd30, 32'hffff_fff0, 32'haaaa_aaaa, 32'h5555_5555};
        foreach (directed[j]) send_sample(directed[j]);
        for (i = 0; i < N_RANDOM; i++) begin
            quiet = (i >= 500 && i < 700);
            if (i == 800) begin
                while (sb.pending() != 0) @(negedge aclk);
            end
            send_sample(rand_sample());
        end
        quiet = 0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        $display("Sent %0d samples, checked %0d results, %0d with the store full.",
                 accepted, sb.checked, sb.drops);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
rtl/rmh_pkg.sv
rtl/rmh_ram.sv
rtl/rmh_ctrl.sv
rtl/rmh_dp.sv
rtl/running_median_two_heaps.sv
tb/testbench.sv
